>>> rtl/tpd_pkg.sv
// tpd_pkg: shared widths, request codes and helper constants for the
// two-particle density element block. No dependencies.
package tpd_pkg;

  localparam int MAX_BASIS  = 128;
  localparam int FRAC_BITS  = 48;
  localparam int DATA_W     = 64;
  localparam int IDX_W      = 7;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DEPTH      = MAX_BASIS * MAX_BASIS;
  localparam int CFG_W      = 8;
  localparam int REQ_W      = 2;
  localparam int OP_W       = DATA_W + 1;
  localparam int PROD_W     = 2 * OP_W;
  localparam int ACC_W      = PROD_W + 4;
  localparam int FIFO_DEPTH = 8;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = FPTR_W + 1;

  localparam logic [REQ_W-1:0] REQ_WRITE_ALPHA = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_BETA  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE     = 2'd2;

  localparam logic [CFG_W-1:0] BASIS_RESET = CFG_W'(128);

  typedef struct packed {
    logic v;
    logic ph;
    logic err;
  } tag_t;

endpackage

>>> rtl/tpd_ifs.sv
// tpd channel interfaces: request, result and configuration channels.
// Depends on tpd_pkg for field widths.
interface tpd_req_if;
  logic                             valid;
  logic                             ready;
  logic [tpd_pkg::REQ_W-1:0]        req_type;
  logic [tpd_pkg::IDX_W-1:0]        index_a;
  logic [tpd_pkg::IDX_W-1:0]        index_b;
  logic [tpd_pkg::IDX_W-1:0]        index_c;
  logic [tpd_pkg::IDX_W-1:0]        index_d;
  logic signed [tpd_pkg::DATA_W-1:0] element_value;
  modport source (output valid, req_type, index_a, index_b, index_c, index_d,
                  element_value, input ready);
  modport sink (input valid, req_type, index_a, index_b, index_c, index_d,
                element_value, output ready);
endinterface

interface tpd_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [tpd_pkg::DATA_W-1:0] gamma_value;
  logic                             index_error;
  logic                             saturated;
  modport source (output valid, gamma_value, index_error, saturated, input ready);
  modport sink (input valid, gamma_value, index_error, saturated, output ready);
endinterface

interface tpd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tpd_pkg::CFG_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/tpd_ram.sv
// tpd_ram: one copy of a density matrix, one write port and two read ports,
// read data registered. Depends on tpd_pkg.
module tpd_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [tpd_pkg::ADDR_W-1:0]    waddr,
  input  logic [tpd_pkg::DATA_W-1:0]    wdata,
  input  logic [tpd_pkg::ADDR_W-1:0]    raddr0,
  input  logic [tpd_pkg::ADDR_W-1:0]    raddr1,
  output logic [tpd_pkg::DATA_W-1:0]    rdata0,
  output logic [tpd_pkg::DATA_W-1:0]    rdata1
);

  logic [tpd_pkg::DATA_W-1:0] mem [tpd_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> rtl/tpd_mul.sv
// tpd_mul: exact signed 65x65 multiplier, split into four ~33x33 partial
// products, two register stages. Depends on tpd_pkg.
module tpd_mul (
  input  logic                                clk,
  input  logic signed [tpd_pkg::OP_W-1:0]     x,
  input  logic signed [tpd_pkg::OP_W-1:0]     y,
  output logic signed [tpd_pkg::PROD_W-1:0]   p
);

  logic [31:0]        xl, yl;
  logic signed [32:0] xh, yh;
  logic [63:0]        pp_ll;
  logic signed [65:0] pp_lh, pp_hl, pp_hh;
  logic signed [tpd_pkg::PROD_W-1:0] s_ll, s_lh, s_hl, s_hh;

  assign xl = x[31:0];
  assign yl = y[31:0];
  assign xh = x[tpd_pkg::OP_W-1:32];
  assign yh = y[tpd_pkg::OP_W-1:32];

  always_ff @(posedge clk) begin
    pp_ll <= xl * yl;
    pp_lh <= $signed({1'b0, xl}) * yh;
    pp_hl <= xh * $signed({1'b0, yl});
    pp_hh <= xh * yh;
  end

  assign s_ll = {66'b0, pp_ll};
  assign s_lh = {{32{pp_lh[65]}}, pp_lh, 32'b0};
  assign s_hl = {{32{pp_hl[65]}}, pp_hl, 32'b0};
  assign s_hh = {pp_hh, 64'b0};

  always_ff @(posedge clk) begin
    p <= s_hh + s_lh + s_hl + s_ll;
  end

endmodule

>>> rtl/two_particle_density_element.sv
// two_particle_density_element: top level; holds alpha and beta density
// matrices and returns two-particle density elements.
// Depends on tpd_pkg, tpd_ifs, tpd_ram and tpd_mul.
//
// Usage:
//   req_ch carries requests: density writes (alpha or beta) and compute
//   queries (a,b,c,d). res_ch returns one result per compute query, in order.
//   cfg_ch writes basis_size; write it only while the block is idle.
//   A write request does not hold off later requests. A compute query reads
//   twelve matrix entries in two phases on the read ports of two copies of
//   each matrix; a request of any kind is held off in the cycle right after
//   a query is taken. Results collect in an 8-entry output queue; apart
//   from that hold, requests are held off only when 8 queries are accepted
//   and not yet delivered, so a stalled receiver does not stop writes or
//   queries until that queue space is used up.
//   Reset (rst, synchronous) empties the pipeline and the queue and sets
//   basis_size to 128; matrix contents are undefined until written.
module two_particle_density_element (
  input  logic   clk,
  input  logic   rst,
  tpd_req_if.sink   req_ch,
  tpd_res_if.source res_ch,
  tpd_cfg_if.sink   cfg_ch
);

  logic [tpd_pkg::CFG_W-1:0] basis_size;
  logic [tpd_pkg::CFG_W-1:0] lim;

  logic in_acc, is_gamma, idx_err, wr_ok, we_a, we_b;
  logic [tpd_pkg::ADDR_W-1:0] waddr;

  // issue stage
  logic                       q_v, q_ph, q_err;
  logic [tpd_pkg::IDX_W-1:0]  q_a, q_b, q_c, q_d;

  logic [tpd_pkg::ADDR_W-1:0] ra0_0, ra0_1, ra1_0, ra1_1;
  logic [tpd_pkg::DATA_W-1:0] a0_r0, a0_r1, a1_r0, a1_r1;
  logic [tpd_pkg::DATA_W-1:0] b0_r0, b0_r1, b1_r0, b1_r1;

  tpd_pkg::tag_t t1, t2, t3, t4, t5;

  logic signed [tpd_pkg::OP_W-1:0]   m0x, m0y, m1x, m1y, m2x, m2y;
  logic signed [tpd_pkg::PROD_W-1:0] p0, p1, p2;
  logic signed [tpd_pkg::ACC_W-1:0]  e0, e1, e2, term, acc, tot, rnd, shifted;
  logic tot_v, tot_err, fits, sat;
  logic [tpd_pkg::DATA_W-1:0] res_val;

  logic [tpd_pkg::DATA_W+1:0] fifo [tpd_pkg::FIFO_DEPTH];
  logic [tpd_pkg::FPTR_W-1:0] wr_ptr, rd_ptr;
  logic [tpd_pkg::FCNT_W-1:0] fcnt, cnt;
  logic out_acc;

  function automatic logic signed [tpd_pkg::OP_W-1:0] sx(
    input logic [tpd_pkg::DATA_W-1:0] v);
    sx = $signed({v[tpd_pkg::DATA_W-1], v});
  endfunction

  // configuration
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      basis_size <= tpd_pkg::BASIS_RESET;
    end else if (cfg_ch.valid) begin
      basis_size <= cfg_ch.data;
    end
  end

  assign lim = (basis_size < tpd_pkg::CFG_W'(tpd_pkg::MAX_BASIS))
             ? basis_size : tpd_pkg::CFG_W'(tpd_pkg::MAX_BASIS);

  // request side
  assign req_ch.ready = !(q_v && !q_ph) && (cnt != tpd_pkg::FCNT_W'(tpd_pkg::FIFO_DEPTH));
  assign in_acc   = req_ch.valid && req_ch.ready;
  assign is_gamma = req_ch.req_type == tpd_pkg::REQ_COMPUTE;
  assign wr_ok    = ({1'b0, req_ch.index_a} < lim) && ({1'b0, req_ch.index_b} < lim);
  assign idx_err  = !wr_ok || !({1'b0, req_ch.index_c} < lim)
                 || !({1'b0, req_ch.index_d} < lim);
  assign we_a  = in_acc && wr_ok && (req_ch.req_type == tpd_pkg::REQ_WRITE_ALPHA);
  assign we_b  = in_acc && wr_ok && (req_ch.req_type == tpd_pkg::REQ_WRITE_BETA);
  assign waddr = {req_ch.index_a, req_ch.index_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
      q_ph <= 1'b0;
    end else if (in_acc && is_gamma) begin
      q_v <= 1'b1;
      q_ph <= 1'b0;
    end else if (q_v && !q_ph) begin
      q_ph <= 1'b1;
    end else begin
      q_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_gamma) begin
      q_a   <= req_ch.index_a;
      q_b   <= req_ch.index_b;
      q_c   <= req_ch.index_c;
      q_d   <= req_ch.index_d;
      q_err <= idx_err;
    end
  end

  // phase 0 reads ab, cd, ac, bd; phase 1 reads ad, bc
  always_comb begin
    if (!q_ph) begin
      ra0_0 = {q_a, q_b};
      ra0_1 = {q_c, q_d};
      ra1_0 = {q_a, q_c};
      ra1_1 = {q_b, q_d};
    end else begin
      ra0_0 = {q_a, q_d};
      ra0_1 = {q_b, q_c};
      ra1_0 = {q_a, q_d};
      ra1_1 = {q_b, q_c};
    end
  end

  tpd_ram u_alpha0 (.clk(clk), .we(we_a), .waddr(waddr), .wdata(req_ch.element_value),
                    .raddr0(ra0_0), .raddr1(ra0_1), .rdata0(a0_r0), .rdata1(a0_r1));
  tpd_ram u_alpha1 (.clk(clk), .we(we_a), .waddr(waddr), .wdata(req_ch.element_value),
                    .raddr0(ra1_0), .raddr1(ra1_1), .rdata0(a1_r0), .rdata1(a1_r1));
  tpd_ram u_beta0  (.clk(clk), .we(we_b), .waddr(waddr), .wdata(req_ch.element_value),
                    .raddr0(ra0_0), .raddr1(ra0_1), .rdata0(b0_r0), .rdata1(b0_r1));
  tpd_ram u_beta1  (.clk(clk), .we(we_b), .waddr(waddr), .wdata(req_ch.element_value),
                    .raddr0(ra1_0), .raddr1(ra1_1), .rdata0(b1_r0), .rdata1(b1_r1));

  // tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
      t5 <= '0;
    end else begin
      t1 <= '{v: q_v, ph: q_ph, err: q_err};
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
      t5 <= t4;
    end
  end

  // operands: phase 0 forms D = Da + Db for the direct term
  always_ff @(posedge clk) begin
    if (!t1.ph) begin
      m0x <= sx(a0_r0) + sx(b0_r0);
      m0y <= sx(a0_r1) + sx(b0_r1);
      m1x <= sx(a1_r0);
      m1y <= sx(a1_r1);
      m2x <= sx(b1_r0);
      m2y <= sx(b1_r1);
    end else begin
      m0x <= sx(a0_r0);
      m0y <= sx(a0_r1);
      m1x <= sx(b0_r0);
      m1y <= sx(b0_r1);
      m2x <= '0;
      m2y <= '0;
    end
  end

  tpd_mul u_mul0 (.clk(clk), .x(m0x), .y(m0y), .p(p0));
  tpd_mul u_mul1 (.clk(clk), .x(m1x), .y(m1y), .p(p1));
  tpd_mul u_mul2 (.clk(clk), .x(m2x), .y(m2y), .p(p2));

  assign e0 = {{(tpd_pkg::ACC_W-tpd_pkg::PROD_W){p0[tpd_pkg::PROD_W-1]}}, p0};
  assign e1 = {{(tpd_pkg::ACC_W-tpd_pkg::PROD_W){p1[tpd_pkg::PROD_W-1]}}, p1};
  assign e2 = {{(tpd_pkg::ACC_W-tpd_pkg::PROD_W){p2[tpd_pkg::PROD_W-1]}}, p2};

  // accumulator holds twice gamma
  always_ff @(posedge clk) begin
    if (!t4.ph) begin
      term <= (e0 <<< 1) - e1 - e2;
    end else begin
      term <= -(e0 + e1);
    end
  end

  always_ff @(posedge clk) begin
    if (t5.v && !t5.ph) begin
      acc <= term;
    end
    if (t5.v && t5.ph) begin
      tot     <= acc + term;
      tot_err <= t5.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tot_v <= 1'b0;
    end else begin
      tot_v <= t5.v && t5.ph;
    end
  end

  // round to nearest (ties up), then saturate to 64 bits; an index error gives zero
  assign rnd     = tot + (tpd_pkg::ACC_W'(1) <<< tpd_pkg::FRAC_BITS);
  assign shifted = rnd >>> (tpd_pkg::FRAC_BITS + 1);
  assign fits    = (&shifted[tpd_pkg::ACC_W-1:tpd_pkg::DATA_W-1])
                || !(|shifted[tpd_pkg::ACC_W-1:tpd_pkg::DATA_W-1]);

  always_comb begin
    priority if (tot_err) begin
      res_val = '0;
      sat     = 1'b0;
    end else if (fits) begin
      res_val = shifted[tpd_pkg::DATA_W-1:0];
      sat     = 1'b0;
    end else begin
      res_val = rnd[tpd_pkg::ACC_W-1] ? {1'b1, {(tpd_pkg::DATA_W-1){1'b0}}}
                                      : {1'b0, {(tpd_pkg::DATA_W-1){1'b1}}};
      sat     = 1'b1;
    end
  end

  // output queue
  assign out_acc = res_ch.valid && res_ch.ready;

  always_ff @(posedge clk) begin
    if (tot_v) begin
      fifo[wr_ptr] <= {res_val, tot_err, sat};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcnt   <= '0;
      cnt    <= '0;
    end else begin
      if (tot_v) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fcnt <= fcnt + tpd_pkg::FCNT_W'(tot_v) - tpd_pkg::FCNT_W'(out_acc);
      cnt  <= cnt + tpd_pkg::FCNT_W'(in_acc && is_gamma) - tpd_pkg::FCNT_W'(out_acc);
    end
  end

  assign res_ch.valid       = fcnt != '0;
  assign res_ch.gamma_value = fifo[rd_ptr][tpd_pkg::DATA_W+1:2];
  assign res_ch.index_error = fifo[rd_ptr][1];
  assign res_ch.saturated   = fifo[rd_ptr][0];

  // checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fcnt <= cnt && cnt <= tpd_pkg::FCNT_W'(tpd_pkg::FIFO_DEPTH))
    else $error("output queue count exceeds requests in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_gamma) |=> !req_ch.ready && q_v && !q_ph)
    else $error("query overlapped its second read phase");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.index_error) |-> (res_ch.gamma_value == '0 && !res_ch.saturated))
    else $error("index error result not cleared");

  a_phase_order: assert property (@(posedge clk) disable iff (rst)
    (t5.v && !t5.ph) |=> (t5.v && t5.ph))
    else $error("query phases split in pipeline");

endmodule

>>> sim/two_particle_density_element_test.sv
// two_particle_density_element_test: self-checking bench for the density block.
// Depends on tpd_pkg, the tpd channel interfaces and the two_particle_density_element top.
module two_particle_density_element_test;

  localparam logic [tpd_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic signed [tpd_pkg::DATA_W-1:0] gamma;
    logic err;
    logic sat;
  } gamma_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpd_req_if req_ch();
  tpd_res_if res_ch();
  tpd_cfg_if cfg_ch();

  two_particle_density_element dut (
    .clk(clk),
    .rst(rst),
    .req_ch(req_ch),
    .res_ch(res_ch),
    .cfg_ch(cfg_ch)
  );

  always #4 clk = ~clk;

  // shadow copy of the block state
  logic signed [tpd_pkg::DATA_W-1:0] alpha_mem [tpd_pkg::DEPTH];
  logic signed [tpd_pkg::DATA_W-1:0] beta_mem [tpd_pkg::DEPTH];
  int basis_bound = 128;
  gamma_result_t gamma_q[$];

  int failures = 0;
  int idle_cycles = 0;
  int n_queries = 0, n_writes = 0, n_ignored = 0;
  int n_err_seen = 0, n_sat_seen = 0;
  bit quiet = 0;
  int pool [16] = '{0, 1, 2, 3, 4, 5, 6, 7, 120, 121, 122, 123, 124, 125, 126, 127};

  task automatic report_mismatch(string what, logic [tpd_pkg::DATA_W-1:0] got,
                                 logic [tpd_pkg::DATA_W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    failures++;
  endtask

  function automatic gamma_result_t density_gamma(int a, int b, int c, int d);
    gamma_result_t r;
    logic signed [tpd_pkg::DATA_W:0] dab, dcd;
    logic signed [135:0] acc;
    int ab, cd, ac, bd, ad, bc;
    r.gamma = '0;
    r.err = 1'b0;
    r.sat = 1'b0;
    if (a >= basis_bound || b >= basis_bound || c >= basis_bound || d >= basis_bound) begin
      r.err = 1'b1;
      return r;
    end
    ab = a * tpd_pkg::MAX_BASIS + b; cd = c * tpd_pkg::MAX_BASIS + d;
    ac = a * tpd_pkg::MAX_BASIS + c; bd = b * tpd_pkg::MAX_BASIS + d;
    ad = a * tpd_pkg::MAX_BASIS + d; bc = b * tpd_pkg::MAX_BASIS + c;
    dab = alpha_mem[ab] + beta_mem[ab];
    dcd = alpha_mem[cd] + beta_mem[cd];
    // twice gamma, exact, in units of 2^-96
    acc = 2 * dab * dcd;
    acc = acc - alpha_mem[ac] * alpha_mem[bd] - alpha_mem[ad] * alpha_mem[bc];
    acc = acc - beta_mem[ac] * beta_mem[bd] - beta_mem[ad] * beta_mem[bc];
    acc = (acc + (136'sd1 <<< tpd_pkg::FRAC_BITS)) >>> (tpd_pkg::FRAC_BITS + 1);
    if (&acc[135:63] || ~|acc[135:63]) begin
      r.gamma = acc[63:0];
    end else begin
      r.sat = 1'b1;
      r.gamma = acc[135] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  function automatic void apply_request(logic [tpd_pkg::REQ_W-1:0] rt, int a, int b, int c,
                                        int d, logic signed [tpd_pkg::DATA_W-1:0] val);
    case (rt)
      tpd_pkg::REQ_WRITE_ALPHA, tpd_pkg::REQ_WRITE_BETA: begin
        n_writes++;
        if (a < basis_bound && b < basis_bound) begin
          if (rt == tpd_pkg::REQ_WRITE_ALPHA) alpha_mem[a * tpd_pkg::MAX_BASIS + b] = val;
          else beta_mem[a * tpd_pkg::MAX_BASIS + b] = val;
        end
      end
      tpd_pkg::REQ_COMPUTE: begin
        n_queries++;
        gamma_q.push_back(density_gamma(a, b, c, d));
      end
      default: n_ignored++;
    endcase
  endfunction

  task automatic send_request(logic [tpd_pkg::REQ_W-1:0] rt, int a, int b, int c, int d,
                              logic signed [tpd_pkg::DATA_W-1:0] val);
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.req_type = rt;
    req_ch.index_a = a[tpd_pkg::IDX_W-1:0];
    req_ch.index_b = b[tpd_pkg::IDX_W-1:0];
    req_ch.index_c = c[tpd_pkg::IDX_W-1:0];
    req_ch.index_d = d[tpd_pkg::IDX_W-1:0];
    req_ch.element_value = val;
    do @(posedge clk); while (!req_ch.ready);
    apply_request(rt, a, b, c, d, val);
  endtask

  task automatic maybe_pause();
    int n;
    if (quiet || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 3);
    @(negedge clk);
    req_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic logic signed [tpd_pkg::DATA_W-1:0] rand_value();
    logic signed [tpd_pkg::DATA_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1: return v;
      2: return v[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      default: return v >>> 12;
    endcase
  endfunction

  function automatic int pick_index();
    int p;
    if (basis_bound == 0) return $urandom_range(0, 127);
    do p = pool[$urandom_range(0, 15)]; while (p >= basis_bound);
    return p;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (gamma_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_basis(logic [tpd_pkg::CFG_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    basis_bound = (value < tpd_pkg::MAX_BASIS) ? value : tpd_pkg::MAX_BASIS;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // fill every pool row/column pair in both spins so queries never see an unwritten entry
  task automatic load_density();
    foreach (pool[i]) foreach (pool[j]) begin
      maybe_pause();
      send_request(tpd_pkg::REQ_WRITE_ALPHA, pool[i], pool[j], 0, 0, rand_value());
      send_request(tpd_pkg::REQ_WRITE_BETA, pool[i], pool[j], 0, 0, rand_value());
    end
  endtask

  task automatic test_directed();
    logic signed [tpd_pkg::DATA_W-1:0] vmax, vmin;
    vmax = {1'b0, {63{1'b1}}};
    vmin = {1'b1, 63'd0};
    send_request(tpd_pkg::REQ_WRITE_ALPHA, 0, 0, 127, 127, vmax);
    send_request(tpd_pkg::REQ_WRITE_BETA, 0, 0, 0, 0, vmax);
    send_request(tpd_pkg::REQ_COMPUTE, 0, 0, 0, 0, vmin);           // positive overflow
    send_request(tpd_pkg::REQ_WRITE_ALPHA, 127, 127, 5, 9, vmin);
    send_request(tpd_pkg::REQ_WRITE_BETA, 127, 127, 0, 0, 64'sd0);
    send_request(tpd_pkg::REQ_COMPUTE, 0, 0, 127, 127, 64'sd0);     // negative overflow
    send_request(tpd_pkg::REQ_COMPUTE, 127, 127, 127, 127, vmax);
    // single-lsb values give tiny results that round to zero
    send_request(tpd_pkg::REQ_WRITE_ALPHA, 1, 1, 0, 0, 64'sd1);
    send_request(tpd_pkg::REQ_WRITE_BETA, 1, 1, 0, 0, 64'sd1);
    send_request(tpd_pkg::REQ_COMPUTE, 1, 1, 1, 1, 64'sd0);
    send_request(tpd_pkg::REQ_WRITE_ALPHA, 1, 1, 0, 0, -64'sd1);
    send_request(tpd_pkg::REQ_COMPUTE, 1, 1, 1, 1, 64'sd0);
    send_request(tpd_pkg::REQ_WRITE_ALPHA, 2, 3, 0, 0, 64'sd1 <<< tpd_pkg::FRAC_BITS);
    send_request(tpd_pkg::REQ_WRITE_BETA, 2, 3, 0, 0,
                 -(64'sd1 <<< (tpd_pkg::FRAC_BITS - 1)));
    send_request(tpd_pkg::REQ_COMPUTE, 2, 3, 3, 2, 64'sd0);
    send_request(tpd_pkg::REQ_COMPUTE, 2, 3, 2, 3, 64'sd0);
    send_request(REQ_UNUSED, 1, 1, 1, 1, vmax);
    send_request(tpd_pkg::REQ_COMPUTE, 120, 7, 127, 0, 64'sd0);
    send_request(tpd_pkg::REQ_COMPUTE, 0, 127, 1, 126, 64'sd0);
  endtask

  task automatic test_random(int count);
    int a, b, c, d, k;
    for (int n = 0; n < count; n++) begin
      maybe_pause();
      a = pick_index(); b = pick_index(); c = pick_index(); d = pick_index();
      k = $urandom_range(0, 99);
      if (k < 45) begin
        send_request(tpd_pkg::REQ_COMPUTE, a, b, c, d, rand_value());
      end else if (k < 52) begin
        // out-of-range query: one index at or past the bound, when the bound is below 128
        if (basis_bound < tpd_pkg::MAX_BASIS) begin
          case ($urandom_range(0, 3))
            0: a = $urandom_range(basis_bound, 127);
            1: b = $urandom_range(basis_bound, 127);
            2: c = $urandom_range(basis_bound, 127);
            default: d = $urandom_range(basis_bound, 127);
          endcase
        end
        send_request(tpd_pkg::REQ_COMPUTE, a, b, c, d, rand_value());
      end else if (k < 88) begin
        send_request($urandom_range(0, 1) ? tpd_pkg::REQ_WRITE_BETA : tpd_pkg::REQ_WRITE_ALPHA,
                     a, b, $urandom_range(0, 127), $urandom_range(0, 127), rand_value());
      end else if (k < 95) begin
        send_request($urandom_range(0, 1) ? tpd_pkg::REQ_WRITE_BETA : tpd_pkg::REQ_WRITE_ALPHA,
                     $urandom_range(0, 127), $urandom_range(0, 127), 0, 0, rand_value());
      end else begin
        send_request(REQ_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 127), $urandom_range(0, 127), rand_value());
      end
    end
  endtask

  // result receiver with random stall bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready = 1'b0;
    end else if (quiet) begin
      res_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready = 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      res_ch.ready = 1'b0;
    end else begin
      res_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    gamma_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (res_ch.index_error) n_err_seen++;
      if (res_ch.saturated) n_sat_seen++;
      if (gamma_q.size() == 0) begin
        report_mismatch("unexpected result", res_ch.gamma_value, 64'd0);
      end else begin
        want = gamma_q.pop_front();
        if (res_ch.gamma_value !== want.gamma)
          report_mismatch("gamma_value", res_ch.gamma_value, want.gamma);
        if (res_ch.index_error !== want.err)
          report_mismatch("index_error", 64'(res_ch.index_error), 64'(want.err));
        if (res_ch.saturated !== want.sat)
          report_mismatch("saturated", 64'(res_ch.saturated), 64'(want.sat));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no progress for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = tpd_pkg::REQ_WRITE_ALPHA;
    req_ch.index_a = '0;
    req_ch.index_b = '0;
    req_ch.index_c = '0;
    req_ch.index_d = '0;
    req_ch.element_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    load_density();
    test_directed();
    test_random(500);
    set_basis(8'd16);
    test_random(300);
    set_basis(8'd1);
    test_random(100);
    set_basis(8'd0);
    test_random(60);
    set_basis(8'd255);
    test_random(150);
    set_basis(8'd128);
    quiet = 1;
    test_random(300);

    wait_idle();
    $display("covered %0d queries, %0d writes, %0d ignored requests", n_queries, n_writes,
             n_ignored);
    $display("basis sizes 128/16/1/0/255; %0d range errors, %0d saturations seen",
             n_err_seen, n_sat_seen);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
